>>> rtl/core/ckv_pkg.sv
// ----------------------------------------------------------------------------
// ckv_pkg
// types and codes shared by the compacting key/value table and its cells
// ----------------------------------------------------------------------------
package ckv_pkg;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_LOOKUP = 2'd2
    } t_action;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_FULL      = 3'd1,
        ST_DUP       = 3'd2,
        ST_EMPTY     = 3'd3,
        ST_NOT_FOUND = 3'd4
    } t_status;

    localparam int unsigned CAP_W = 4;

    typedef struct packed {
        logic [1:0]         action;
        logic signed [31:0] key;
        logic [63:0]        payload_in;
    } t_req;

    typedef struct packed {
        logic [2:0]       status;
        logic [63:0]      payload_out;
        logic [CAP_W-1:0] occupancy;
    } t_rsp;

    typedef struct packed {
        logic signed [31:0] key;
        logic [63:0]        payload;
    } t_entry;

    typedef struct packed {
        logic occupied;
        logic load;
        logic shift;
    } t_cell_ctl;

endpackage

>>> rtl/core/ckv_cell.sv
// ----------------------------------------------------------------------------
// ckv_cell
// one table slot: holds a key and payload, compares against the request key,
// loads a new entry or takes its upper neighbour's entry when a gap closes
// ----------------------------------------------------------------------------
module ckv_cell import ckv_pkg::*; (
    input  logic               i_clk,
    input  t_cell_ctl          i_ctl,
    input  logic signed [31:0] i_req_key,
    input  t_entry             i_new,
    input  t_entry             i_next,
    output t_entry             o_entry,
    output logic               o_match
);

    t_entry r_entry;
    t_entry n_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.load) begin
            n_entry = i_new;
        end else if (i_ctl.shift) begin
            n_entry = i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;
    assign o_match = i_ctl.occupied && (r_entry.key == i_req_key);

endmodule

>>> rtl/core/compacting_key_value_table.sv
// ----------------------------------------------------------------------------
// compacting_key_value_table
// Associative table of up to ENTRIES unique signed keys with 64-bit payloads,
// packed from slot 0 in insertion order across a row of cells. Each transfer
// is an insert, remove or lookup; every cell compares its key in the same
// cycle and a remove shifts all later cells down one slot at the same edge,
// so one request is taken per clock unless the input stalls, and its result
// is captured in the output register at the accepting edge. The input stalls
// only while that register holds a result that the output side is stalling.
// Capacity above ENTRIES acts as ENTRIES; zero makes every insert answer full.
// ----------------------------------------------------------------------------
module compacting_key_value_table import ckv_pkg::*; #(
    parameter int unsigned ENTRIES = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_req             i_in,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_rsp             o_out,
    input  logic             i_cfg_we,
    input  logic [CAP_W-1:0] i_cfg_wdata
);

    localparam int unsigned CW = $clog2(ENTRIES + 1);
    localparam int unsigned UW = (CW > CAP_W) ? CW : CAP_W;

    logic [CAP_W-1:0] r_cap;
    logic [CW-1:0]    r_count;
    logic [CW-1:0]    n_count;
    logic             r_out_valid;
    t_rsp             r_out;

    t_entry               entry [ENTRIES];
    logic [ENTRIES-1:0]   match;
    logic                 hit;
    logic [63:0]          hit_payload;
    logic                 in_acc;
    logic                 do_insert;
    logic                 do_remove;
    logic                 full;
    logic [UW-1:0]        cap_ext;
    logic [UW-1:0]        usable;
    t_status              status;
    logic [63:0]          pout;
    t_entry               new_entry;

    assign in_acc     = i_in_valid && !o_in_stall;
    assign o_in_stall = r_out_valid && i_out_stall;
    assign new_entry  = '{key: i_in.key, payload: i_in.payload_in};

    generate
        for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
            localparam logic [ENTRIES-1:0] LE_MASK = {ENTRIES{1'b1}} >> (ENTRIES - 1 - g);
            t_cell_ctl ctl;
            t_entry    next_entry;

            if (g < ENTRIES - 1) begin : g_mid
                assign next_entry = entry[g+1];
            end else begin : g_last
                assign next_entry = entry[g];
            end

            assign ctl.occupied = (CW'(g) < r_count);
            assign ctl.load     = do_insert && (r_count == CW'(g));
            assign ctl.shift    = do_remove && (|(match & LE_MASK));

            ckv_cell u_cell (
                .i_clk     (i_clk),
                .i_ctl     (ctl),
                .i_req_key (i_in.key),
                .i_new     (new_entry),
                .i_next    (next_entry),
                .o_entry   (entry[g]),
                .o_match   (match[g])
            );
        end
    endgenerate

    // keys are unique, so at most one cell matches
    always_comb begin
        hit_payload = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            hit_payload = hit_payload | ({64{match[i]}} & entry[i].payload);
        end
    end

    assign hit     = |match;
    assign cap_ext = UW'(r_cap);
    assign usable  = (cap_ext > UW'(ENTRIES)) ? UW'(ENTRIES) : cap_ext;
    assign full    = (UW'(r_count) >= usable);

    always_comb begin
        status    = ST_OK;
        pout      = '0;
        do_insert = 1'b0;
        do_remove = 1'b0;
        n_count   = r_count;
        case (i_in.action)
            ACT_INSERT: begin
                if (full) begin
                    status = ST_FULL;
                end else if (hit) begin
                    status = ST_DUP;
                end else begin
                    do_insert = in_acc;
                    n_count   = r_count + 1'b1;
                end
            end
            ACT_REMOVE: begin
                if (r_count == '0) begin
                    status = ST_EMPTY;
                end else if (!hit) begin
                    status = ST_NOT_FOUND;
                end else begin
                    do_remove = in_acc;
                    n_count   = r_count - 1'b1;
                end
            end
            ACT_LOOKUP: begin
                if (r_count == '0) begin
                    status = ST_EMPTY;
                end else if (!hit) begin
                    status = ST_NOT_FOUND;
                end else begin
                    pout = hit_payload;
                end
            end
            default: begin
                status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= CAP_W'(8);
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            if (in_acc) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_out.status      <= status;
            r_out.payload_out <= pout;
            r_out.occupancy   <= CAP_W'(n_count);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(ENTRIES))
        else $error("entry count beyond table depth");

    a_unique_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(match))
        else $error("more than one cell matches the request key");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_insert |=> r_count == CW'($past(r_count) + 1'b1))
        else $error("insert did not advance the entry count");

    a_remove_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_remove |=> r_count == CW'($past(r_count) - 1'b1))
        else $error("remove did not reduce the entry count");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_out_valid && (o_out.occupancy == CAP_W'(r_count)))
        else $error("result occupancy does not match the table");
`endif

endmodule
